// ===== rtl/gcs_pkg.sv =====
// ============================================================================
// gcs_pkg: shared types and constants for the greedy change block
// Holds the command and status codes, controller states and control structs.
// ============================================================================
`default_nettype none

package gcs_pkg;

    localparam int unsigned NUM_SLOTS_DEF   = 16;
    localparam int unsigned VALUE_WIDTH_DEF = 32;
    localparam int unsigned SLOT_W          = 4;
    localparam int unsigned COUNT_W         = 32;
    localparam int unsigned STATUS_W        = 3;

    typedef enum logic [1:0] {
        K_LOAD    = 2'd0,
        K_ADD     = 2'd1,
        K_REMOVE  = 2'd2,
        K_REQUEST = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_CHANGE  = 3'd1,
        ST_BAD_SLOT   = 3'd2,
        ST_UNDERFLOW  = 3'd3,
        ST_WRONG_MODE = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OP,
        S_WALK,
        S_DIV,
        S_TAKE,
        S_CHECK,
        S_EMIT_SCAN,
        S_EMIT_WAIT,
        S_STATUS
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the accepted input item
        logic do_op;      // perform load/add/remove on the latched item
        logic walk_init;  // start a change walk at slot zero
        logic div_start;  // start a division for the current slot
        logic take;       // apply quotient of current slot
        logic next_slot;  // advance slot pointer
        logic emit_init;  // start emitting from slot zero
        logic emit_cnt;   // load output register with current slot's count
        logic emit_stat;  // load output register with status item
        logic fail;       // status item carries no exact change
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic      is_request;
        logic      slot_end;      // slot pointer has passed the last slot
        logic      rem_zero;
        logic      denom_zero;
        logic      div_done;
        logic      sol_nonzero;
        logic      out_busy;      // output register still holds an item
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/greedy_change_with_stock_top.sv =====
// ============================================================================
// greedy_change_with_stock_top: greedy coin change with limited stock
// Top level joining the sequencing controller and the table datapath.
// ============================================================================
// The input channel (i_valid/o_stall) carries one command transaction:
// load a slot, add stock, remove stock, or request change for an amount.
// The output channel (o_valid/i_stall) carries result transactions; each
// command ends with one status transaction that has o_last set.
// A load or stock command is latched on acceptance and then applied; its
// status is loaded into the output register once that register is free.
// A change request walks every slot; each slot with a nonzero denomination
// and a nonzero remainder runs the bit-serial divider, and a request can
// also be held up by stalls at the output.
// One command is processed at a time; o_stall stays high until the last
// result of the previous command has been loaded into the output register.
// When the receiver stalls, the output register holds its transaction.
// Synchronous reset clears the denomination and stock tables, the remainder
// and the handshake state, and sets the limited-stock mode.
// The configuration channel writes stock_limited; it is always ready.
// ============================================================================
`default_nettype none

module greedy_change_with_stock_top
    import gcs_pkg::*;
#(
    parameter int unsigned NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_data,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [1:0]          i_kind,
    input  wire logic [SLOT_W-1:0]   i_slot,
    input  wire logic [COUNT_W-1:0]  i_value,
    input  wire logic [COUNT_W-1:0]  i_stock_count,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [SLOT_W-1:0]        o_out_slot,
    output logic [COUNT_W-1:0]       o_coin_count,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  r_limited;

    assign o_cfg_ready = 1'b1;

    // Mode register; software must change it only while idle (unenforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limited <= 1'b1;
        end else if (i_cfg_valid) begin
            r_limited <= i_cfg_data;
        end
    end

    gcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    gcs_datapath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_limited     (r_limited),
        .i_kind        (i_kind),
        .i_slot        (i_slot),
        .i_value       (i_value),
        .i_stock_count (i_stock_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_slot    (o_out_slot),
        .o_coin_count  (o_coin_count),
        .o_status      (o_status),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    // A new command is never taken while a result is still being produced.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("command accepted while busy");

    // A coin-count item never carries a nonzero status.
    a_count_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_status == ST_OK))
        else $error("coin item with error status");

    // An emission is only ordered when the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_cnt || w_cmd.emit_stat) |-> !o_valid)
        else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

// ===== rtl/gcs_div.sv =====
// ============================================================================
// gcs_div: restoring divider
// Unsigned division, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module gcs_div
    import gcs_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_num,
    input  wire logic [VALUE_WIDTH-1:0] i_den,
    output logic                        o_done,
    output logic [VALUE_WIDTH-1:0]      o_quot
);

    localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_quot, n_quot;
    logic [VALUE_WIDTH:0]   r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_den;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic [VALUE_WIDTH:0]   w_shift;

    always_comb begin
        w_shift = {r_rem[VALUE_WIDTH-1:0], r_quot[VALUE_WIDTH-1]};
        n_quot  = {r_quot[VALUE_WIDTH-2:0], 1'b0};
        n_rem   = w_shift;
        if (w_shift >= {1'b0, r_den}) begin
            n_rem     = w_shift - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_WIDTH);
            end else if (r_busy) begin
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/gcs_datapath.sv =====
// ============================================================================
// gcs_datapath: tables, divider and output register
// Holds denomination, stock and solution tables and forms result items.
// ============================================================================
`default_nettype none

module gcs_datapath
    import gcs_pkg::*;
#(
    parameter int unsigned NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic                i_limited,
    input  wire logic [1:0]          i_kind,
    input  wire logic [SLOT_W-1:0]   i_slot,
    input  wire logic [COUNT_W-1:0]  i_value,
    input  wire logic [COUNT_W-1:0]  i_stock_count,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [SLOT_W-1:0]        o_out_slot,
    output logic [COUNT_W-1:0]       o_coin_count,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_last
);

    localparam int unsigned PW = $clog2(NUM_SLOTS + 1);
    localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [VALUE_WIDTH-1:0] VMAX = '1;

    logic [VALUE_WIDTH-1:0] r_denom [NUM_SLOTS];
    logic [VALUE_WIDTH-1:0] r_stock [NUM_SLOTS];
    logic [VALUE_WIDTH-1:0] r_sol   [NUM_SLOTS];
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [1:0]             r_kind;
    logic [SLOT_W-1:0]      r_slot;
    logic [VALUE_WIDTH-1:0] r_value, r_scount;
    logic [PW-1:0]          r_ptr;
    logic [IW-1:0]          w_idx;
    logic [VALUE_WIDTH-1:0] w_d, w_s, w_quot, w_take, w_prod;
    logic                   w_div_done;
    logic                   w_slot_ok;
    logic [IW-1:0]          w_oidx;
    t_status                w_op_status;

    assign w_idx     = r_ptr[IW-1:0];
    assign w_oidx    = IW'(r_slot);
    assign w_d       = r_denom[w_idx];
    assign w_s       = r_stock[w_idx];
    assign w_slot_ok = ({28'd0, r_slot} < 32'(NUM_SLOTS));

    gcs_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_rem),
        .i_den   (w_d),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // A skipped slot (zero denomination or nothing left to pay) takes no coins.
    assign w_take = (w_d == '0 || r_rem == '0) ? '0 :
                    ((i_limited && w_quot > w_s) ? w_s : w_quot);
    assign w_prod = VALUE_WIDTH'(w_take * w_d);

    always_comb begin
        w_op_status = ST_OK;
        if (t_kind'(r_kind) == K_LOAD) begin
            if (!w_slot_ok) w_op_status = ST_BAD_SLOT;
        end else if (!i_limited) begin
            w_op_status = ST_WRONG_MODE;
        end else if (!w_slot_ok) begin
            w_op_status = ST_BAD_SLOT;
        end else if (t_kind'(r_kind) == K_REMOVE && r_stock[w_oidx] < r_value) begin
            w_op_status = ST_UNDERFLOW;
        end
    end

    always_comb begin
        o_stat.is_request  = (t_kind'(r_kind) == K_REQUEST);
        o_stat.slot_end    = (r_ptr == PW'(NUM_SLOTS));
        o_stat.rem_zero    = (r_rem == '0);
        o_stat.denom_zero  = (w_d == '0);
        o_stat.div_done    = w_div_done;
        o_stat.sol_nonzero = (r_sol[w_idx] != '0);
        o_stat.out_busy    = o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_denom[i] <= '0;
                r_stock[i] <= '0;
            end
            r_rem   <= '0;
            r_ptr   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            if (i_cmd.do_op && w_op_status == ST_OK) begin
                case (t_kind'(r_kind))
                    K_LOAD: begin
                        r_denom[w_oidx] <= r_value;
                        r_stock[w_oidx] <= r_scount;
                    end
                    K_ADD: begin
                        if (r_value > VMAX - r_stock[w_oidx]) r_stock[w_oidx] <= VMAX;
                        else r_stock[w_oidx] <= r_stock[w_oidx] + r_value;
                    end
                    K_REMOVE: r_stock[w_oidx] <= r_stock[w_oidx] - r_value;
                    default: ;
                endcase
            end
            if (i_cmd.walk_init) begin
                r_rem <= r_value;
                r_ptr <= '0;
            end
            if (i_cmd.emit_init) r_ptr <= '0;
            if (i_cmd.next_slot) r_ptr <= r_ptr + PW'(1);
            if (i_cmd.take) r_rem <= r_rem - w_prod;
            if (i_cmd.emit_cnt) begin
                if (i_limited) r_stock[w_idx] <= r_stock[w_idx] - r_sol[w_idx];
                o_valid      <= 1'b1;
                o_out_slot   <= SLOT_W'(r_ptr);
                o_coin_count <= COUNT_W'(r_sol[w_idx]);
                o_status     <= ST_OK;
                o_last       <= 1'b0;
            end
            if (i_cmd.emit_stat) begin
                o_valid      <= 1'b1;
                o_out_slot   <= '0;
                o_coin_count <= '0;
                o_last       <= 1'b1;
                if (i_cmd.fail) o_status <= ST_NO_CHANGE;
                else if (t_kind'(r_kind) == K_REQUEST) o_status <= ST_OK;
                else o_status <= w_op_status;
            end
        end
    end

    // Solution store: every entry is rewritten as the walk passes its slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_slot   <= i_slot;
            r_value  <= VALUE_WIDTH'(i_value);
            r_scount <= VALUE_WIDTH'(i_stock_count);
        end
        if (i_cmd.take) r_sol[w_idx] <= w_take;
    end

endmodule

`default_nettype wire

// ===== rtl/gcs_ctrl.sv =====
// ============================================================================
// gcs_ctrl: sequencing state machine
// Steps through operations, the change walk and result emission.
// ============================================================================
`default_nettype none

module gcs_ctrl
    import gcs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_fail, n_fail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fail  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fail  <= n_fail;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fail  = r_fail;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_cmd.fail = r_fail;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_OP;
                end
            end
            S_OP: begin
                n_fail = 1'b0;
                if (i_stat.is_request) begin
                    o_cmd.walk_init = 1'b1;
                    n_state = S_WALK;
                end else if (!i_stat.out_busy) begin
                    o_cmd.do_op     = 1'b1;
                    o_cmd.emit_stat = 1'b1;
                    o_cmd.fail      = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (i_stat.slot_end) begin
                    n_state = S_CHECK;
                end else if (i_stat.denom_zero || i_stat.rem_zero) begin
                    o_cmd.take = 1'b0;
                    n_state = S_TAKE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_TAKE;
            end
            S_TAKE: begin
                // A skipped slot records zero coins; the datapath masks the quotient.
                o_cmd.take      = 1'b1;
                o_cmd.next_slot = 1'b1;
                n_state = S_WALK;
            end
            S_CHECK: begin
                if (!i_stat.rem_zero) begin
                    n_fail = 1'b1;
                    n_state = S_STATUS;
                end else begin
                    o_cmd.emit_init = 1'b1;
                    n_state = S_EMIT_SCAN;
                end
            end
            S_EMIT_SCAN: begin
                if (i_stat.slot_end) begin
                    n_state = S_STATUS;
                end else if (!i_stat.sol_nonzero) begin
                    o_cmd.next_slot = 1'b1;
                end else if (!i_stat.out_busy) begin
                    o_cmd.emit_cnt  = 1'b1;
                    o_cmd.next_slot = 1'b1;
                end
            end
            S_STATUS: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit_stat = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/greedy_change_with_stock_top_tb.sv =====
// ============================================================================
// greedy_change_with_stock_top_tb: self-checking bench for the change block
// Drives load, stock and change-request transactions, predicts every result
// transaction from its own copy of the coin tables, and compares in order.
// ============================================================================
`default_nettype none

module greedy_change_with_stock_top_tb;
    import gcs_pkg::*;

    localparam int unsigned SLOTS     = NUM_SLOTS_DEF;
    localparam int unsigned MAX_CYCLE = 1_500_000;

    typedef struct {
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
        t_status            status;
        logic               last;
    } t_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_data = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [1:0]          i_kind = 2'd0;
    logic [SLOT_W-1:0]   i_slot = '0;
    logic [COUNT_W-1:0]  i_value = '0;
    logic [COUNT_W-1:0]  i_stock_count = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [SLOT_W-1:0]   o_out_slot;
    logic [COUNT_W-1:0]  o_coin_count;
    logic [STATUS_W-1:0] o_status;
    logic                o_last;

    // Bench-side image of the block's state.
    logic [COUNT_W-1:0] denom_img [SLOTS];
    logic [COUNT_W-1:0] stock_img [SLOTS];
    logic               limited_img = 1'b1;
    t_result            pending_results [$];

    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned requests_paid = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_cycles = 0;

    greedy_change_with_stock_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_slot(i_slot), .i_value(i_value),
        .i_stock_count(i_stock_count),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_slot(o_out_slot), .o_coin_count(o_coin_count),
        .o_status(o_status), .o_last(o_last)
    );

    always #1 i_clk = ~i_clk;

    // Run limit: reckoned far above the slowest legal run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("greedy_change_with_stock_top_tb: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off while hold_cycles runs down.
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycles);
        errors++;
    endtask

    // Every accepted result transaction is compared against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, slot", 0, o_out_slot);
            end else begin
                want = pending_results.pop_front();
                if (o_out_slot !== want.slot)
                    report_mismatch("out_slot", want.slot, o_out_slot);
                if (o_coin_count !== want.count)
                    report_mismatch("coin_count", want.count, o_coin_count);
                if (o_status !== want.status)
                    report_mismatch("status", want.status, o_status);
                if (o_last !== want.last)
                    report_mismatch("last", want.last, o_last);
            end
        end
    end

    function automatic void push_result(input logic [SLOT_W-1:0] slot,
                                        input logic [COUNT_W-1:0] count,
                                        input t_status status, input logic last);
        t_result r;
        r.slot = slot;
        r.count = count;
        r.status = status;
        r.last = last;
        pending_results.push_back(r);
    endfunction

    // Greedy walk over the table image; stock only changes on exact payment.
    function automatic void predict_change(input logic [COUNT_W-1:0] amount);
        logic [COUNT_W-1:0] taken [SLOTS];
        longint unsigned rem;
        longint unsigned take;
        rem = amount;
        for (int i = 0; i < SLOTS; i++) begin
            taken[i] = '0;
            if (rem != 0 && denom_img[i] != 0) begin
                take = rem / denom_img[i];
                if (limited_img && take > stock_img[i])
                    take = stock_img[i];
                taken[i] = take[COUNT_W-1:0];
                rem = rem - take * denom_img[i];
            end
        end
        if (rem != 0) begin
            push_result('0, '0, ST_NO_CHANGE, 1'b1);
        end else begin
            requests_paid++;
            for (int i = 0; i < SLOTS; i++) begin
                if (taken[i] != 0) begin
                    if (limited_img)
                        stock_img[i] = stock_img[i] - taken[i];
                    push_result(i[SLOT_W-1:0], taken[i], ST_OK, 1'b0);
                end
            end
            push_result('0, '0, ST_OK, 1'b1);
        end
    endfunction

    function automatic void predict_command(input t_kind kind,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [COUNT_W-1:0] value,
                                            input logic [COUNT_W-1:0] scount);
        t_status st;
        longint unsigned sum;
        st = ST_OK;
        if (kind == K_REQUEST) begin
            predict_change(value);
            return;
        end
        // The slot field cannot exceed the table, so the bad-slot path is unreachable.
        if (kind == K_LOAD) begin
            denom_img[slot] = value;
            stock_img[slot] = scount;
        end else if (!limited_img) begin
            st = ST_WRONG_MODE;
        end else if (kind == K_ADD) begin
            sum = longint'(stock_img[slot]) + value;
            stock_img[slot] = (sum > 64'hFFFF_FFFF) ? '1 : sum[COUNT_W-1:0];
        end else begin
            if (stock_img[slot] < value)
                st = ST_UNDERFLOW;
            else
                stock_img[slot] = stock_img[slot] - value;
        end
        push_result('0, '0, st, 1'b1);
    endfunction

    // Offers one command transaction, with random idle cycles ahead of it.
    task automatic send_cmd(input t_kind kind, input logic [SLOT_W-1:0] slot,
                            input logic [COUNT_W-1:0] value,
                            input logic [COUNT_W-1:0] scount);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_slot <= slot;
        i_value <= value;
        i_stock_count <= scount;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_command(kind, slot, value, scount);
        items_sent++;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        // Allow the controller to return to idle after its last status.
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic limited);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= limited;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        limited_img = limited;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [COUNT_W-1:0] pick_denom();
        int unsigned r;
        r = $urandom_range(11);
        case (r)
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'd2;
            3:       return 32'd5;
            4:       return 32'd10;
            5:       return 32'd20;
            6:       return 32'd25;
            7:       return 32'd50;
            8:       return 32'd100;
            9:       return 32'd3;
            10:      return $urandom_range(1, 300);
            default: return $urandom();
        endcase
    endfunction

    // Mostly a coin set plus payable requests; some noise with full-width values.
    task automatic random_cmd;
        int unsigned r;
        logic [SLOT_W-1:0] s;
        r = $urandom_range(99);
        s = $urandom_range(SLOTS - 1);
        if (r < 15)
            send_cmd(K_LOAD, s, pick_denom(),
                     ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 30));
        else if (r < 27)
            send_cmd(K_ADD, s, ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 20),
                     $urandom());
        else if (r < 37)
            send_cmd(K_REMOVE, s,
                     ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 10),
                     $urandom());
        else
            send_cmd(K_REQUEST, s,
                     ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 800),
                     $urandom());
    endtask

    task automatic load_coin_set;
        logic [COUNT_W-1:0] coins [8] = '{32'd100, 32'd50, 32'd25, 32'd10,
                                         32'd5, 32'd2, 32'd1, 32'd0};
        for (int i = 0; i < 8; i++)
            send_cmd(K_LOAD, i[SLOT_W-1:0], coins[i], $urandom_range(3, 40));
    endtask

    task automatic test_directed;
        idle_pct = 0;
        stall_pct = 0;
        send_cmd(K_REQUEST, 4'd0, 32'd0, '0);          // zero amount: only the ok status
        send_cmd(K_REQUEST, 4'd3, 32'd7, '0);          // empty table: no exact change
        send_cmd(K_LOAD, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(K_ADD, 4'd15, 32'hFFFF_FFFF, '0);     // saturates the stock
        send_cmd(K_REQUEST, 4'd0, 32'hFFFF_FFFF, '1);  // one coin of the widest value
        send_cmd(K_LOAD, 4'd0, 32'd0, 32'd9);          // zero denomination is skipped
        send_cmd(K_LOAD, 4'd1, 32'd10, 32'd2);
        send_cmd(K_LOAD, 4'd2, 32'd1, 32'd3);
        send_cmd(K_REQUEST, 4'd0, 32'd23, '0);         // paid: 2x10 + 3x1
        send_cmd(K_REQUEST, 4'd0, 32'd1, '0);          // stock exhausted: fails
        send_cmd(K_REMOVE, 4'd1, 32'd1, '0);           // more than held: underflow
        send_cmd(K_ADD, 4'd1, 32'd5, '0);
        send_cmd(K_REMOVE, 4'd1, 32'd5, '0);           // exactly what is held
        send_cmd(K_REMOVE, 4'd1, 32'd0, '0);
        write_mode(1'b0);
        send_cmd(K_ADD, 4'd1, 32'd1, '0);              // refused in unlimited mode
        send_cmd(K_REMOVE, 4'd7, 32'hFFFF_FFFF, '0);
        send_cmd(K_REQUEST, 4'd0, 32'd47, '0);         // stock ignored: 4x10 + 7x1
        send_cmd(K_LOAD, 4'd2, 32'd0, 32'hA5A5_5A5A);
        send_cmd(K_REQUEST, 4'd0, 32'd47, '0);         // remainder 7 is left unpaid
        write_mode(1'b1);
    endtask

    task automatic test_random(input int unsigned n, input int unsigned idle,
                               input int unsigned stall);
        idle_pct = idle;
        stall_pct = stall;
        load_coin_set();
        for (int i = 0; i < n; i++) random_cmd();
    endtask

    // Receiver holds off while requests keep coming, so the input backs up.
    task automatic test_backpressure;
        idle_pct = 0;
        stall_pct = 0;
        load_coin_set();
        hold_cycles = 3000;
        for (int i = 0; i < 6; i++)
            send_cmd(K_REQUEST, 4'd0, $urandom_range(1, 400), '0);
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            denom_img[i] = '0;
            stock_img[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(35, 0, 0);
        test_random(26, 74, 0);
        test_random(26, 0, 74);
        write_mode(1'b0);
        test_random(24, 22, 22);
        write_mode(1'b1);
        test_random(26, 22, 22);
        test_backpressure();
        drain();

        $display("Covered %0d commands, %0d results, %0d paid requests,",
                 items_sent, results_seen, requests_paid);
        $display("both stock modes, random idling and a long output hold-off.");
        if (errors == 0) begin
            $display("greedy_change_with_stock_top_tb: done, clean");
        end else begin
            $display("greedy_change_with_stock_top_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
